[design/qtpi_pkg.sv]
// ---------------------------------------------------------------------------
// qtpi_pkg: shared types and constants for the quadtree point insert block
// Field widths, register indexes, queue entry, result and state types.
// ---------------------------------------------------------------------------
package qtpi_pkg;

  // default sizes of the node table and of the level limit
  localparam int NODE_SLOTS_DEF  = 4096;
  localparam int LEVEL_LIMIT_DEF = 16;

  // fixed field widths
  localparam int COORD_W    = 16;
  localparam int TAG_W      = 16;
  localparam int NODE_IDX_W = 12;
  localparam int AREA_W     = 17;
  localparam int LEVELS_W   = 5;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // tree constants
  localparam int ROOT_NODE  = 3;
  localparam int GROUP_SIZE = 4;
  localparam int FREE_RESET = 4;
  localparam logic [1:0] EAST_BIT  = 2'b01;
  localparam logic [1:0] SOUTH_BIT = 2'b10;

  // register indexes
  localparam logic [1:0] REG_AREA_WIDTH  = 2'd0;
  localparam logic [1:0] REG_AREA_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MAX_LEVELS  = 2'd2;

  // register reset values
  localparam logic [AREA_W-1:0]   AREA_RESET   = 17'd256;
  localparam logic [LEVELS_W-1:0] LEVELS_RESET = 5'd8;

  typedef struct packed {
    logic [AREA_W-1:0]   area_width;
    logic [AREA_W-1:0]   area_height;
    logic [LEVELS_W-1:0] max_levels;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic [TAG_W-1:0]   tag;
    logic               rejected;
  } item_t;

  typedef struct packed {
    logic [NODE_IDX_W-1:0] node_index;
    logic [TAG_W-1:0]      tag;
    logic                  last_node;
    logic                  rejected;
    logic                  table_full;
  } result_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_CHECK,
    BK_EVAL
  } back_state_t;

endpackage

[design/quadtree_point_insert.sv]
// ---------------------------------------------------------------------------
// quadtree_point_insert: point insertion into an implicit quadtree
// Walks each point from the root, allocates child groups, emits visited nodes.
// ---------------------------------------------------------------------------
// Usage:
//   Configuration: APB-style port, area_width at 0x0, area_height at 0x4,
//   max_levels at 0x8; write only while no insertion is under way.
//   Requests: start with in_point_x, in_point_y, in_payload_tag is taken at
//   an edge with busy low; two requests can wait ahead of the tree walker.
//   Results: one per visited node, root first, one cycle each with out_valid
//   high; out_last_node marks the last; the receiver cannot stall.
//   Sequence: the walker takes a request, then per level reads the child
//   table, then evaluates and writes, and ends with a closing check; a
//   full table cuts the descent short at the evaluate step, and an outside
//   point gives a single flagged result with no walk.
//   Reset: the child table is cleared one entry per cycle, all NODE_SLOTS
//   entries (4096 by default), with busy high; registers return to defaults.
// ---------------------------------------------------------------------------
module quadtree_point_insert #(
  parameter int NODE_SLOTS  = qtpi_pkg::NODE_SLOTS_DEF,
  parameter int LEVEL_LIMIT = qtpi_pkg::LEVEL_LIMIT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [qtpi_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [qtpi_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [qtpi_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  // request channel
  input  logic                              start,
  output logic                              busy,
  input  logic [qtpi_pkg::COORD_W-1:0]      in_point_x,
  input  logic [qtpi_pkg::COORD_W-1:0]      in_point_y,
  input  logic [qtpi_pkg::TAG_W-1:0]        in_payload_tag,
  // result channel
  output logic                              out_valid,
  output logic [qtpi_pkg::NODE_IDX_W-1:0]   out_node_index,
  output logic [qtpi_pkg::TAG_W-1:0]        out_tag_out,
  output logic                              out_last_node,
  output logic                              out_rejected,
  output logic                              out_table_full
);

  qtpi_pkg::cfg_t    cfg_r, cfg_nxt;
  qtpi_pkg::item_t   front_item;
  qtpi_pkg::item_t   q_head;
  qtpi_pkg::result_t res;
  logic              cfg_wr;
  logic              push;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  logic              clearing;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        qtpi_pkg::REG_AREA_WIDTH:  cfg_nxt.area_width  = pwdata[qtpi_pkg::AREA_W-1:0];
        qtpi_pkg::REG_AREA_HEIGHT: cfg_nxt.area_height = pwdata[qtpi_pkg::AREA_W-1:0];
        qtpi_pkg::REG_MAX_LEVELS:  cfg_nxt.max_levels  = pwdata[qtpi_pkg::LEVELS_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.area_width  <= qtpi_pkg::AREA_RESET;
      cfg_r.area_height <= qtpi_pkg::AREA_RESET;
      cfg_r.max_levels  <= qtpi_pkg::LEVELS_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[3:2])
      qtpi_pkg::REG_AREA_WIDTH:  prdata = qtpi_pkg::CFG_DATA_W'(cfg_r.area_width);
      qtpi_pkg::REG_AREA_HEIGHT: prdata = qtpi_pkg::CFG_DATA_W'(cfg_r.area_height);
      qtpi_pkg::REG_MAX_LEVELS:  prdata = qtpi_pkg::CFG_DATA_W'(cfg_r.max_levels);
      default:                   prdata = '0;
    endcase
  end

  // request intake
  qtpi_front u_front (
    .start       (start),
    .point_x     (in_point_x),
    .point_y     (in_point_y),
    .payload_tag (in_payload_tag),
    .cfg         (cfg_r),
    .queue_full  (q_full),
    .clearing    (clearing),
    .busy        (busy),
    .push        (push),
    .item        (front_item)
  );

  // request queue
  qtpi_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .pop       (q_pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head)
  );

  // tree walker
  qtpi_back #(
    .NODE_SLOTS  (NODE_SLOTS),
    .LEVEL_LIMIT (LEVEL_LIMIT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .res_valid (out_valid),
    .res       (res)
  );

  // result ports
  assign out_node_index = res.node_index;
  assign out_tag_out    = res.tag;
  assign out_last_node  = res.last_node;
  assign out_rejected   = res.rejected;
  assign out_table_full = res.table_full;

endmodule

[design/qtpi_front.sv]
// ---------------------------------------------------------------------------
// qtpi_front: request intake and classification
// Accepts a point, flags it when it lies outside the area and queues it.
// ---------------------------------------------------------------------------
module qtpi_front (
  input  logic                        start,
  input  logic [qtpi_pkg::COORD_W-1:0] point_x,
  input  logic [qtpi_pkg::COORD_W-1:0] point_y,
  input  logic [qtpi_pkg::TAG_W-1:0]   payload_tag,
  input  qtpi_pkg::cfg_t               cfg,
  input  logic                        queue_full,
  input  logic                        clearing,
  output logic                        busy,
  output logic                        push,
  output qtpi_pkg::item_t             item
);

  // hold off requests while the queue is full or the table is being cleared
  assign busy = queue_full | clearing;
  assign push = start & ~busy;

  // outside-area check on the incoming point
  always_comb begin
    item.point_x  = point_x;
    item.point_y  = point_y;
    item.tag      = payload_tag;
    item.rejected = ({1'b0, point_x} >= cfg.area_width) |
                    ({1'b0, point_y} >= cfg.area_height);
  end

endmodule

[design/qtpi_queue.sv]
// ---------------------------------------------------------------------------
// qtpi_queue: small request queue between front and back
// Circular buffer of classified requests with occupancy count.
// ---------------------------------------------------------------------------
module qtpi_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  qtpi_pkg::item_t push_item,
  input  logic            pop,
  output logic            full,
  output logic            valid,
  output qtpi_pkg::item_t head
);

  localparam int PW = (qtpi_pkg::QUEUE_DEPTH > 1) ? $clog2(qtpi_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(qtpi_pkg::QUEUE_DEPTH + 1);

  qtpi_pkg::item_t entries_r [qtpi_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full  = (count_r == CW'(qtpi_pkg::QUEUE_DEPTH));
  assign valid = (count_r != '0);
  assign head  = entries_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(qtpi_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(qtpi_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[design/qtpi_back.sv]
// ---------------------------------------------------------------------------
// qtpi_back: tree walker
// Clears the child table after reset, then walks each queued point down the
// tree one level at a time, allocating child groups and emitting nodes.
// ---------------------------------------------------------------------------
module qtpi_back #(
  parameter int NODE_SLOTS  = qtpi_pkg::NODE_SLOTS_DEF,
  parameter int LEVEL_LIMIT = qtpi_pkg::LEVEL_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  qtpi_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  qtpi_pkg::item_t   q_head,
  output logic              q_pop,
  output logic              clearing,
  output logic              res_valid,
  output qtpi_pkg::result_t res
);

  localparam int NW = $clog2(NODE_SLOTS);
  localparam int FW = NW + 1;
  localparam int LW = $clog2(LEVEL_LIMIT + 1);
  localparam int AW = qtpi_pkg::AREA_W;

  qtpi_pkg::back_state_t state_r, state_nxt;

  logic [NW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [NW-1:0] node_r, node_nxt;
  logic [qtpi_pkg::TAG_W-1:0]   tag_r, tag_nxt;
  logic [qtpi_pkg::COORD_W-1:0] px_r, px_nxt;
  logic [qtpi_pkg::COORD_W-1:0] py_r, py_nxt;
  logic [LW-1:0] levels_r, levels_nxt;
  logic [LW-1:0] depth_r, depth_nxt;
  logic [AW-1:0] left_r, left_nxt;
  logic [AW-1:0] top_r, top_nxt;
  logic [AW-1:0] w_r, w_nxt;
  logic [AW-1:0] h_r, h_nxt;
  logic [AW-1:0] cx_r, cx_nxt;
  logic [AW-1:0] cy_r, cy_nxt;
  logic [FW-1:0] nfg_r, nfg_nxt;

  logic              res_valid_r, res_valid_nxt;
  qtpi_pkg::result_t res_r, res_nxt;

  // child table
  logic [NW-1:0] child_mem [NODE_SLOTS];
  logic [NW-1:0] rd_data_r;
  logic          mem_we;
  logic [NW-1:0] mem_waddr;
  logic [NW-1:0] mem_wdata;
  logic          mem_re;

  // per-level working values
  logic          done_walk;
  logic          table_out;
  logic [1:0]    quad;
  logic [NW-1:0] first;
  logic [AW-1:0] left_new, top_new, w_new, h_new;

  assign clearing  = (state_r == qtpi_pkg::BK_CLEAR);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  assign done_walk = (depth_r >= levels_r) || ((w_r <= AW'(1)) && (h_r <= AW'(1)));
  assign table_out = ({1'b0, nfg_r} + (FW+1)'(qtpi_pkg::GROUP_SIZE)) >
                     (FW+1)'(NODE_SLOTS);

  // quadrant choice and child geometry
  always_comb begin
    quad[0] = ({1'b0, px_r} >= cx_r);
    quad[1] = ({1'b0, py_r} >= cy_r);
    if ((quad & qtpi_pkg::EAST_BIT) != '0) begin
      left_new = cx_r;
      w_new    = w_r - (w_r >> 1);
    end else begin
      left_new = left_r;
      w_new    = w_r >> 1;
    end
    if ((quad & qtpi_pkg::SOUTH_BIT) != '0) begin
      top_new = cy_r;
      h_new   = h_r - (h_r >> 1);
    end else begin
      top_new = top_r;
      h_new   = h_r >> 1;
    end
  end

  // walker state machine
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    node_nxt      = node_r;
    tag_nxt       = tag_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    levels_nxt    = levels_r;
    depth_nxt     = depth_r;
    left_nxt      = left_r;
    top_nxt       = top_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    nfg_nxt       = nfg_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = node_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    first         = rd_data_r;
    res_valid_nxt = 1'b0;
    res_nxt.node_index = 12'(node_r);
    res_nxt.tag        = tag_r;
    res_nxt.last_node  = 1'b0;
    res_nxt.rejected   = 1'b0;
    res_nxt.table_full = 1'b0;

    unique case (state_r)
      qtpi_pkg::BK_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == NW'(NODE_SLOTS - 1)) begin
          state_nxt = qtpi_pkg::BK_IDLE;
        end
      end

      qtpi_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_head.rejected) begin
            // point outside the area: one flagged result, tree untouched
            res_valid_nxt      = 1'b1;
            res_nxt.node_index = '0;
            res_nxt.tag        = q_head.tag;
            res_nxt.last_node  = 1'b1;
            res_nxt.rejected   = 1'b1;
          end else begin
            tag_nxt  = q_head.tag;
            px_nxt   = q_head.point_x;
            py_nxt   = q_head.point_y;
            node_nxt = NW'(qtpi_pkg::ROOT_NODE);
            if (32'(cfg.max_levels) > LEVEL_LIMIT) begin
              levels_nxt = LW'(LEVEL_LIMIT);
            end else begin
              levels_nxt = LW'(cfg.max_levels);
            end
            depth_nxt = '0;
            left_nxt  = '0;
            top_nxt   = '0;
            w_nxt     = cfg.area_width;
            h_nxt     = cfg.area_height;
            cx_nxt    = cfg.area_width >> 1;
            cy_nxt    = cfg.area_height >> 1;
            state_nxt = qtpi_pkg::BK_CHECK;
          end
        end
      end

      qtpi_pkg::BK_CHECK: begin
        if (done_walk) begin
          // current node is the final one
          res_valid_nxt     = 1'b1;
          res_nxt.last_node = 1'b1;
          state_nxt         = qtpi_pkg::BK_IDLE;
        end else begin
          mem_re    = 1'b1;
          state_nxt = qtpi_pkg::BK_EVAL;
        end
      end

      qtpi_pkg::BK_EVAL: begin
        if ((rd_data_r == '0) && table_out) begin
          // no group left: stop at the current node
          res_valid_nxt      = 1'b1;
          res_nxt.last_node  = 1'b1;
          res_nxt.table_full = 1'b1;
          state_nxt          = qtpi_pkg::BK_IDLE;
        end else begin
          if (rd_data_r == '0) begin
            // leaf: allocate a fresh group of four
            first     = NW'(nfg_r);
            nfg_nxt   = nfg_r + FW'(qtpi_pkg::GROUP_SIZE);
            mem_we    = 1'b1;
            mem_waddr = node_r;
            mem_wdata = NW'(nfg_r);
          end
          res_valid_nxt = 1'b1;
          node_nxt  = first + NW'(quad);
          depth_nxt = depth_r + 1'b1;
          left_nxt  = left_new;
          top_nxt   = top_new;
          w_nxt     = w_new;
          h_nxt     = h_new;
          cx_nxt    = left_new + (w_new >> 1);
          cy_nxt    = top_new + (h_new >> 1);
          state_nxt = qtpi_pkg::BK_CHECK;
        end
      end

      default: begin
        state_nxt = qtpi_pkg::BK_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qtpi_pkg::BK_CLEAR;
      clr_cnt_r   <= '0;
      nfg_r       <= FW'(qtpi_pkg::FREE_RESET);
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      nfg_r       <= nfg_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // walk payload registers
  always_ff @(posedge clk) begin
    node_r   <= node_nxt;
    tag_r    <= tag_nxt;
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    levels_r <= levels_nxt;
    depth_r  <= depth_nxt;
    left_r   <= left_nxt;
    top_r    <= top_nxt;
    w_r      <= w_nxt;
    h_r      <= h_nxt;
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    res_r    <= res_nxt;
  end

  // child table port: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      child_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= child_mem[node_r];
    end
  end

endmodule
